// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the MACD crossover unit.
// Define NO_ASSERTIONS to compile every macro to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property holds at every clock edge outside reset.
`define MCS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Condition a implies condition b on the following edge.
`define MCS_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define MCS_ASSERT(lbl, clk, rst_n, prop)
`define MCS_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

// ----- rtl/mcs_pkg.sv -----
// ----------------------------------------------------------------------------
// mcs_pkg
// Shared types and constants of the MACD crossover signal unit.
// ----------------------------------------------------------------------------
package mcs_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ACC_WIDTH_DEF = 48;

    localparam logic [7:0] FAST_RESET   = 8'd12;
    localparam logic [7:0] SLOW_RESET   = 8'd26;
    localparam logic [7:0] SIGNAL_RESET = 8'd9;

    localparam logic [9:0] IDX_MAX = 10'd1023;

    typedef enum logic [1:0]
    {
        REG_FAST   = 2'd0,
        REG_SLOW   = 2'd1,
        REG_SIGNAL = 2'd2
    } reg_index_t;

    typedef enum logic [1:0]
    {
        ACT_NONE = 2'd0,
        ACT_BUY  = 2'd1,
        ACT_SELL = 2'd2
    } action_t;

    typedef enum logic
    {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } alu_op_t;

    typedef struct packed
    {
        logic    start;
        alu_op_t op;
    } alu_ctrl_t;

endpackage

// ----- rtl/mcs_alu.sv -----
// ----------------------------------------------------------------------------
// mcs_alu
// Shared iterative unit: radix-2 restoring divide or shift-add multiply.
// ----------------------------------------------------------------------------
module mcs_alu
    import mcs_pkg::*;
#(
    parameter int RW = 67,
    parameter int MW = 17
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  alu_ctrl_t     ctrl,
    input  logic [RW-1:0] a,
    input  logic [MW-1:0] b,
    output logic          done,
    output logic [RW-1:0] result
);

    localparam int CW = $clog2(RW + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    alu_op_t       op_reg;
    logic [RW-1:0] a_reg;
    logic [MW-1:0] b_reg;
    logic [RW-1:0] acc_reg;
    logic [MW-1:0] rem_reg;

    logic [MW:0]   rem_sh;
    logic          q_bit;
    logic [MW:0]   rem_sub;

    always_comb
    begin
        rem_sh  = {rem_reg, a_reg[RW-1]};
        q_bit   = (rem_sh >= {1'b0, b_reg});
        rem_sub = rem_sh - {1'b0, b_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
        end
        else if (ctrl.start)
        begin
            busy_reg <= 1'b1;
            op_reg   <= ctrl.op;
            cnt_reg  <= (ctrl.op == OP_DIV) ? CW'(RW) : CW'(MW);
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - CW'(1);
            done_reg <= (cnt_reg == CW'(1));
            busy_reg <= (cnt_reg != CW'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_DIV)
            begin
                // shift in one dividend bit, subtract when it fits
                rem_reg <= q_bit ? rem_sub[MW-1:0] : rem_sh[MW-1:0];
                a_reg   <= {a_reg[RW-2:0], q_bit};
            end
            else
            begin
                if (b_reg[0])
                begin
                    acc_reg <= acc_reg + a_reg;
                end
                a_reg <= {a_reg[RW-2:0], 1'b0};
                b_reg <= {1'b0, b_reg[MW-1:1]};
            end
        end
    end

    assign done   = done_reg;
    assign result = (op_reg == OP_DIV) ? a_reg : acc_reg;

endmodule

// ----- rtl/macd_crossover_signal_unit.sv -----
// ----------------------------------------------------------------------------
// macd_crossover_signal_unit
// MACD indicator with signal line, histogram and crossover trade actions.
// ----------------------------------------------------------------------------
// One price beat gives one result beat. The three averages are worked one
// after another through a single shared iterative unit. The seed adds a
// restoring divide of the running sum by the period. A steady update takes a
// divide for the smoothing factor plus a shift-add multiply. All of these run
// on the shared divide/multiply unit; s_tready is high only between items.
// A finished result waits in the output register while the next price is
// taken. Period registers are written over APB at byte addresses 0, 4, 8.
module macd_crossover_signal_unit
    import mcs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int ACC_WIDTH = ACC_WIDTH_DEF,
    localparam int OUT_W    = ((3 * ACC_WIDTH + 64 + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    // APB configuration
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // price stream
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [63:0]      s_tdata,   // close_price, date_tag
    input  logic             s_tuser,   // first_of_series
    // result stream
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // macd, signal, histogram, date_out, price_out
    output logic [1:0]       m_tuser    // action
);

    `include "assert_macros.svh"

    localparam int ACC   = ACC_WIDTH;
    localparam int SUM_W = ACC + 8;
    localparam int MW    = FRAC_BITS + 1;
    localparam int PW    = ACC + 1 + MW + 1;
    localparam int RW    = (PW > SUM_W) ? PW : SUM_W;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_EVAL,
        ST_SEED_WAIT,
        ST_M_WAIT,
        ST_MUL_WAIT,
        ST_NEXT,
        ST_OUT
    } state_t;

    state_t state_reg;

    logic [7:0] fast_reg;
    logic [7:0] slow_reg;
    logic [7:0] signal_reg;

    logic [9:0]                   idx_reg;
    logic signed [ACC-1:0]        avg_reg [3];
    logic signed [SUM_W-1:0]      sum_reg [3];
    logic signed [ACC-1:0]        prev_hist_reg;
    logic                         hold_reg;
    logic signed [ACC-1:0]        macd_reg;
    logic [1:0]                   k_reg;
    logic                         neg_reg;
    logic [31:0]                  price_reg;
    logic [31:0]                  date_reg;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic signed [ACC-1:0]        out_macd_reg;
    logic signed [ACC-1:0]        out_sig_reg;
    logic signed [ACC-1:0]        out_hist_reg;
    action_t                      out_action_reg;
    logic [31:0]                  out_date_reg;
    logic [31:0]                  out_price_reg;

    alu_ctrl_t                    alu_ctrl_reg;
    alu_ctrl_t                    alu_ctrl_next;
    logic [RW-1:0]                alu_a_reg;
    logic [MW-1:0]                alu_b_reg;
    logic                         alu_done;
    logic [RW-1:0]                alu_result;

    // config port
    logic       cfg_wr;
    reg_index_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_index_t'(paddr[3:2]);

    always_comb
    begin
        case (cfg_idx)
            REG_FAST:   prdata = {24'd0, fast_reg};
            REG_SLOW:   prdata = {24'd0, slow_reg};
            REG_SIGNAL: prdata = {24'd0, signal_reg};
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_reg   <= FAST_RESET;
            slow_reg   <= SLOW_RESET;
            signal_reg <= SIGNAL_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_FAST:   fast_reg   <= pwdata[7:0];
                REG_SLOW:   slow_reg   <= pwdata[7:0];
                REG_SIGNAL: signal_reg <= pwdata[7:0];
                default:    ;
            endcase
        end
    end

    // current average: period, input, seed compare
    logic [7:0]              p_raw;
    logic [8:0]              p_eff;
    logic [10:0]             idx_p1;
    logic signed [ACC-1:0]   x_cur;
    logic signed [SUM_W-1:0] sum_new;
    logic [SUM_W-1:0]        sum_mag;
    logic signed [ACC:0]     diff;
    logic [8:0]              slow_eff;
    logic                    macd_zero;
    logic signed [SUM_W-1:0] quot;
    logic signed [SUM_W-1:0] seed_val;
    logic signed [ACC-1:0]   step_val;
    logic signed [ACC-1:0]   hist;
    logic [8:0]              xover_bound;
    logic                    xover_on;
    logic                    buy;
    logic                    sell;
    logic                    out_free;

    always_comb
    begin
        case (k_reg)
            2'd0:    p_raw = fast_reg;
            2'd1:    p_raw = slow_reg;
            default: p_raw = signal_reg;
        endcase
        p_eff    = (p_raw == 8'd0) ? 9'd1 : {1'b0, p_raw};
        slow_eff = (slow_reg == 8'd0) ? 9'd1 : {1'b0, slow_reg};
        idx_p1   = {1'b0, idx_reg} + 11'd1;
        x_cur    = (k_reg == 2'd2) ? macd_reg : $signed({{(ACC-32){1'b0}}, price_reg});
        sum_new  = sum_reg[k_reg] + {{(SUM_W-ACC){x_cur[ACC-1]}}, x_cur};
        sum_mag  = sum_new[SUM_W-1] ? (-sum_new) : sum_new;
        diff     = {x_cur[ACC-1], x_cur} - {avg_reg[k_reg][ACC-1], avg_reg[k_reg]};
        macd_zero = (idx_p1 < {2'b00, slow_eff});
        quot     = $signed(alu_result[SUM_W-1:0]);
        seed_val = neg_reg ? (-quot) : quot;
        step_val = avg_reg[k_reg] + $signed(alu_result[FRAC_BITS +: ACC]);
        hist     = macd_reg - avg_reg[2];
        xover_bound = {1'b0, slow_reg} + {1'b0, signal_reg};
        xover_on = (idx_reg != 10'd0) && (idx_reg > {1'b0, xover_bound});
        buy      = xover_on && !hold_reg && (prev_hist_reg <= 0) && (hist > 0);
        sell     = xover_on && hold_reg && (prev_hist_reg >= 0) && (hist < 0);
        out_free = !out_valid_reg || m_tready;
    end

    // start pulses for the shared unit and the result valid flag
    always_comb
    begin
        alu_ctrl_next  = '{start: 1'b0, op: alu_ctrl_reg.op};
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ST_EVAL:
            begin
                if (idx_p1 >= {2'b00, p_eff})
                begin
                    alu_ctrl_next = '{start: 1'b1, op: OP_DIV};
                end
            end
            ST_M_WAIT:
            begin
                if (alu_done)
                begin
                    alu_ctrl_next = '{start: 1'b1, op: OP_MUL};
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            alu_ctrl_reg  <= '{start: 1'b0, op: OP_MUL};
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            hold_reg      <= 1'b0;
            prev_hist_reg <= '0;
            k_reg         <= 2'd0;
            for (int j = 0; j < 3; j++)
            begin
                avg_reg[j] <= '0;
                sum_reg[j] <= '0;
            end
        end
        else
        begin
            alu_ctrl_reg  <= alu_ctrl_next;
            out_valid_reg <= out_valid_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        k_reg <= 2'd0;
                        if (s_tuser)
                        begin
                            idx_reg       <= '0;
                            hold_reg      <= 1'b0;
                            prev_hist_reg <= '0;
                            for (int j = 0; j < 3; j++)
                            begin
                                avg_reg[j] <= '0;
                                sum_reg[j] <= '0;
                            end
                        end
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL:
                begin
                    if (idx_p1 < {2'b00, p_eff})
                    begin
                        sum_reg[k_reg] <= sum_new;
                        state_reg      <= ST_NEXT;
                    end
                    else if (idx_p1 == {2'b00, p_eff})
                    begin
                        // seed: truncated mean of the first samples
                        sum_reg[k_reg] <= sum_new;
                        state_reg      <= ST_SEED_WAIT;
                    end
                    else
                    begin
                        state_reg <= ST_M_WAIT;
                    end
                end
                ST_SEED_WAIT:
                begin
                    if (alu_done)
                    begin
                        avg_reg[k_reg] <= seed_val[ACC-1:0];
                        state_reg      <= ST_NEXT;
                    end
                end
                ST_M_WAIT:
                begin
                    if (alu_done)
                    begin
                        state_reg <= ST_MUL_WAIT;
                    end
                end
                ST_MUL_WAIT:
                begin
                    if (alu_done)
                    begin
                        avg_reg[k_reg] <= step_val;
                        state_reg      <= ST_NEXT;
                    end
                end
                ST_NEXT:
                begin
                    if (k_reg == 2'd2)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= ST_EVAL;
                    end
                end
                ST_OUT:
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        prev_hist_reg <= hist;
                        if (buy)
                        begin
                            hold_reg <= 1'b1;
                        end
                        else if (sell)
                        begin
                            hold_reg <= 1'b0;
                        end
                        if (idx_reg < IDX_MAX)
                        begin
                            idx_reg <= idx_reg + 10'd1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_tvalid)
        begin
            price_reg <= s_tdata[31:0];
            date_reg  <= s_tdata[63:32];
        end
        if (state_reg == ST_EVAL)
        begin
            if (idx_p1 == {2'b00, p_eff})
            begin
                neg_reg   <= sum_new[SUM_W-1];
                alu_a_reg <= {{(RW-SUM_W){1'b0}}, sum_mag};
                alu_b_reg <= MW'(p_eff);
            end
            else
            begin
                alu_a_reg <= {{(RW-1){1'b0}}, 1'b1} << (FRAC_BITS + 1);
                alu_b_reg <= MW'(p_eff + 9'd1);
            end
        end
        if (state_reg == ST_M_WAIT && alu_done)
        begin
            alu_a_reg <= {{(RW-ACC-1){diff[ACC]}}, diff};
            alu_b_reg <= alu_result[MW-1:0];
        end
        if (state_reg == ST_NEXT && k_reg == 2'd1)
        begin
            macd_reg <= macd_zero ? '0 : (avg_reg[0] - avg_reg[1]);
        end
        if (state_reg == ST_OUT && out_free)
        begin
            out_macd_reg   <= macd_reg;
            out_sig_reg    <= avg_reg[2];
            out_hist_reg   <= hist;
            out_action_reg <= buy ? ACT_BUY : (sell ? ACT_SELL : ACT_NONE);
            out_date_reg   <= date_reg;
            out_price_reg  <= price_reg;
        end
    end

    mcs_alu #(
        .RW (RW),
        .MW (MW)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (alu_ctrl_reg),
        .a      (alu_a_reg),
        .b      (alu_b_reg),
        .done   (alu_done),
        .result (alu_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_action_reg;
    assign m_tdata  = OUT_W'({out_price_reg, out_date_reg, out_hist_reg, out_sig_reg,
                              out_macd_reg});

    `MCS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `MCS_ASSERT(a_done_when_waiting, clk, rst_n,
        !alu_done || state_reg == ST_SEED_WAIT || state_reg == ST_M_WAIT ||
        state_reg == ST_MUL_WAIT)
    `MCS_ASSERT(a_buy_positive, clk, rst_n,
        !(out_valid_reg && out_action_reg == ACT_BUY) || (out_hist_reg > 0))

endmodule
